/* src/acs_pkg.sv */
// Package with the action codes, character constants and text of the AT command serializer.
package acs_pkg;

    localparam logic [2:0] ACT_PLAY_FILE     = 3'd0;
    localparam logic [2:0] ACT_SET_VOLUME    = 3'd1;
    localparam logic [2:0] ACT_QUERY_CURRENT = 3'd2;
    localparam logic [2:0] ACT_QUERY_TOTAL   = 3'd3;
    localparam logic [2:0] ACT_LED_OFF       = 3'd4;
    localparam logic [2:0] ACT_PLAY_MODE     = 3'd5;

    // Register index decoded from paddr[2].
    localparam logic REG_VOLUME_LIMIT = 1'b0;
    localparam logic [7:0] VOLUME_LIMIT_RESET = 8'd30;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;

    // Text is right-aligned: the first character sits in the highest used byte.
    localparam logic [127:0] TXT_PLAYNUM = {40'h0, "AT+PLAYNUM="};
    localparam logic [127:0] TXT_VOL     = {72'h0, "AT+VOL="};
    localparam logic [127:0] TXT_QUERY1  = {32'h0, "AT+QUERY=1", CHAR_CR, CHAR_LF};
    localparam logic [127:0] TXT_QUERY2  = {32'h0, "AT+QUERY=2", CHAR_CR, CHAR_LF};
    localparam logic [127:0] TXT_LED     = {32'h0, "AT+LED=OFF", CHAR_CR, CHAR_LF};
    localparam logic [127:0] TXT_MODE    = {8'h0, "AT+PLAYMODE=3", CHAR_CR, CHAR_LF};

    localparam logic [3:0] LEN_PLAYNUM = 4'd11;
    localparam logic [3:0] LEN_VOL     = 4'd7;
    localparam logic [3:0] LEN_QUERY   = 4'd12;
    localparam logic [3:0] LEN_LED     = 4'd12;
    localparam logic [3:0] LEN_MODE    = 4'd15;

    function automatic logic [7:0] text_byte(input logic [127:0] txt, input logic [3:0] len,
                                             input logic [3:0] idx);
        logic [3:0] pos;
        pos = len - 4'd1 - idx;
        return txt[{pos, 3'b000} +: 8];
    endfunction

endpackage

/* src/at_command_serializer_unit.sv */
// Top level of the AT command serializer: APB register, item register, byte sequencer, output register.
// The first byte of a line reaches out_byte through the item register, the byte sequencer and the output register.
// Throughput: one byte per cycle while out_ready is not held low; a line is 10 to 16 bytes long, walked by the
// byte sequencer, and the next item waits in the item register meanwhile.
// Actions 6 and 7 are taken and produce no bytes.
// Reset (rst_n low, asynchronous) empties all stages and sets volume_limit to 30.
module at_command_serializer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    logic [7:0] volume_limit_reg;

    logic       item_valid_reg;
    logic [2:0] item_action_reg;
    logic [7:0] item_value_reg;

    logic       seq_valid_reg;
    logic [2:0] seq_action_reg;
    logic [3:0] seq_idx_reg;
    logic [3:0] hund_reg;
    logic [3:0] tens_reg;
    logic [3:0] units_reg;
    logic [1:0] ndig_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg;

    logic       in_xfer;
    logic       seq_adv;
    logic       seq_load;
    logic       seq_done;
    logic [7:0] clamped_value;

    logic [3:0] hund_next;
    logic [6:0] rem_value;
    logic [14:0] tens_prod;
    logic [3:0] tens_next;
    logic [3:0] units_next;
    logic [1:0] ndig_next;

    logic [3:0] pre_len;
    logic [3:0] line_len;
    logic [3:0] dig_pos;
    logic [3:0] digit;
    logic [7:0] cur_byte;
    logic       cur_last;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == acs_pkg::REG_VOLUME_LIMIT) ? {24'h0, volume_limit_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_limit_reg <= acs_pkg::VOLUME_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == acs_pkg::REG_VOLUME_LIMIT)
        begin
            volume_limit_reg <= pwdata[7:0];
        end
    end

    // Handshake control
    assign seq_adv  = seq_valid_reg && (!out_valid_reg || out_ready);
    assign seq_done = seq_adv && cur_last;
    assign seq_load = item_valid_reg && (!seq_valid_reg || seq_done);
    assign in_ready = !item_valid_reg || seq_load;
    assign in_xfer  = in_valid && in_ready;

    assign clamped_value = (action == acs_pkg::ACT_SET_VOLUME && value > volume_limit_reg)
                           ? volume_limit_reg : value;

    // Item register; unused action codes are dropped here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            item_valid_reg <= (action <= acs_pkg::ACT_PLAY_MODE);
        end
        else if (seq_load)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_action_reg <= action;
            item_value_reg  <= clamped_value;
        end
    end

    // Decimal split of the item value. The tens digit uses 205/2048 as 1/10,
    // which is exact for remainders below 100.
    always_comb
    begin
        if (item_value_reg >= 8'd200)
        begin
            hund_next = 4'd2;
            rem_value = 7'(item_value_reg - 8'd200);
        end
        else if (item_value_reg >= 8'd100)
        begin
            hund_next = 4'd1;
            rem_value = 7'(item_value_reg - 8'd100);
        end
        else
        begin
            hund_next = 4'd0;
            rem_value = item_value_reg[6:0];
        end
        tens_prod  = 15'(rem_value) * 15'd205;
        tens_next  = tens_prod[14:11];
        units_next = 4'(rem_value - 7'(tens_next) * 7'd10);
        if (hund_next != 4'd0)
        begin
            ndig_next = 2'd3;
        end
        else if (tens_next != 4'd0)
        begin
            ndig_next = 2'd2;
        end
        else
        begin
            ndig_next = 2'd1;
        end
    end

    // Byte sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            seq_idx_reg   <= 4'd0;
        end
        else if (seq_load)
        begin
            seq_valid_reg <= 1'b1;
            seq_idx_reg   <= 4'd0;
        end
        else if (seq_done)
        begin
            seq_valid_reg <= 1'b0;
        end
        else if (seq_adv)
        begin
            seq_idx_reg <= seq_idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            seq_action_reg <= item_action_reg;
            hund_reg       <= hund_next;
            tens_reg       <= tens_next;
            units_reg      <= units_next;
            ndig_reg       <= ndig_next;
        end
    end

    always_comb
    begin
        pre_len = (seq_action_reg == acs_pkg::ACT_PLAY_FILE) ? acs_pkg::LEN_PLAYNUM
                                                             : acs_pkg::LEN_VOL;
        dig_pos = seq_idx_reg - pre_len;
        if (dig_pos == 4'({2'b00, ndig_reg} - 4'd1))
        begin
            digit = units_reg;
        end
        else if (dig_pos == 4'({2'b00, ndig_reg} - 4'd2))
        begin
            digit = tens_reg;
        end
        else
        begin
            digit = hund_reg;
        end

        line_len = 4'd0;
        cur_byte = 8'h00;
        unique case (seq_action_reg)
            acs_pkg::ACT_PLAY_FILE, acs_pkg::ACT_SET_VOLUME:
            begin
                line_len = 4'(pre_len + {2'b00, ndig_reg} + 4'd2);
                if (seq_idx_reg < pre_len)
                begin
                    cur_byte = (seq_action_reg == acs_pkg::ACT_PLAY_FILE)
                        ? acs_pkg::text_byte(acs_pkg::TXT_PLAYNUM, pre_len, seq_idx_reg)
                        : acs_pkg::text_byte(acs_pkg::TXT_VOL, pre_len, seq_idx_reg);
                end
                else if (dig_pos < {2'b00, ndig_reg})
                begin
                    cur_byte = acs_pkg::CHAR_ZERO + {4'h0, digit};
                end
                else if (dig_pos == {2'b00, ndig_reg})
                begin
                    cur_byte = acs_pkg::CHAR_CR;
                end
                else
                begin
                    cur_byte = acs_pkg::CHAR_LF;
                end
            end
            acs_pkg::ACT_QUERY_CURRENT:
            begin
                line_len = acs_pkg::LEN_QUERY;
                cur_byte = acs_pkg::text_byte(acs_pkg::TXT_QUERY1, line_len, seq_idx_reg);
            end
            acs_pkg::ACT_QUERY_TOTAL:
            begin
                line_len = acs_pkg::LEN_QUERY;
                cur_byte = acs_pkg::text_byte(acs_pkg::TXT_QUERY2, line_len, seq_idx_reg);
            end
            acs_pkg::ACT_LED_OFF:
            begin
                line_len = acs_pkg::LEN_LED;
                cur_byte = acs_pkg::text_byte(acs_pkg::TXT_LED, line_len, seq_idx_reg);
            end
            acs_pkg::ACT_PLAY_MODE:
            begin
                line_len = acs_pkg::LEN_MODE;
                cur_byte = acs_pkg::text_byte(acs_pkg::TXT_MODE, line_len, seq_idx_reg);
            end
            default:
            begin
                line_len = 4'd1;
                cur_byte = 8'h00;
            end
        endcase
        cur_last = (seq_idx_reg == 4'(line_len - 4'd1));
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_adv)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    a_item_action_used: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> item_action_reg <= acs_pkg::ACT_PLAY_MODE)
        else $error("item register holds an unused action code");

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid_reg |-> hund_reg <= 4'd2 && tens_reg <= 4'd9 && units_reg <= 4'd9
                          && ndig_reg != 2'd0)
        else $error("decimal digits out of range");

    // A 16-byte line wraps line_len to zero, so the bound is taken as length minus one.
    a_index_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid_reg |-> seq_idx_reg <= 4'(line_len - 4'd1))
        else $error("sequencer index ran past the end of the line");

    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> out_byte_reg == acs_pkg::CHAR_LF)
        else $error("final byte of a line is not a line feed");

endmodule
